FILE: design/rhfd_pkg.sv
// Shared types and constants for the RTP H.264 FU-A depacketizer.
package rhfd_pkg;

  localparam int MAX_PACKET_DEF = 2048;
  localparam int CMD_DEPTH_DEF  = 4;

  // Packet byte positions
  localparam int HDR_LEN      = 12;
  localparam int SEQ_HI_POS   = 2;
  localparam int SEQ_LO_POS   = 3;
  localparam int TS_FIRST_POS = 4;
  localparam int TS_LAST_POS  = 7;

  localparam logic [4:0] FU_A_TYPE     = 5'h1c;
  localparam logic [2:0] FU_START_FLAG = 3'b100;
  localparam logic [2:0] FU_END_FLAG   = 3'b010;

  // Start code burst: 00 00 00 01 then the NAL header
  localparam int         START_BEATS    = 5;
  localparam int         BEAT_W         = 3;
  localparam int         CODE_ONE_BEAT  = 3;
  localparam logic [7:0] START_CODE_END = 8'h01;

  typedef enum logic [1:0] {
    KIND_SINGLE,
    KIND_FU_START,
    KIND_FU_MIDDLE,
    KIND_FU_END
  } kind_t;

  typedef enum logic [1:0] {
    ST_DATA,
    ST_NO_DATA,
    ST_TOO_SHORT
  } status_t;

  typedef enum logic [1:0] {
    OP_DATA,
    OP_START,
    OP_NO_DATA,
    OP_TOO_SHORT
  } op_t;

  // Command from the classifier to the output sequencer
  typedef struct packed {
    op_t         op;
    logic [7:0]  data;   // payload byte, or NAL header for OP_START
    logic        last;
    logic [15:0] seq;
    logic [31:0] ts;
    kind_t       kind;
    logic [4:0]  ntype;
    logic        gap;
  } cmd_t;

endpackage

FILE: design/rhfd_front.sv
// Classifier: tracks packet position and header state, issues one command per useful byte.
module rhfd_front #(
  parameter int MAX_PACKET = rhfd_pkg::MAX_PACKET_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           take,
  input  logic [7:0]     in_byte,
  input  logic           in_last,
  output rhfd_pkg::cmd_t cmd,
  output logic           cmd_push
);

  localparam int              POS_W   = $clog2(MAX_PACKET);
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_PACKET - 1);

  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic [15:0]         seq_r, seq_nxt;
  logic [15:0]         prev_r, prev_nxt;
  logic [31:0]         ts_r, ts_nxt;
  logic [7:0]          fui_r, fui_nxt;
  rhfd_pkg::kind_t     mode_r, mode_nxt;
  rhfd_pkg::kind_t     fu_kind;
  logic                gap;
  logic                err;
  logic                has_cmd;

  always_comb begin
    seq_nxt  = seq_r;
    ts_nxt   = ts_r;
    fui_nxt  = fui_r;
    mode_nxt = mode_r;
    prev_nxt = prev_r;
    pos_nxt  = pos_r;
    err      = 1'b0;
    has_cmd  = 1'b0;

    if (pos_r == POS_W'(rhfd_pkg::SEQ_HI_POS)) begin
      seq_nxt = {in_byte, seq_r[7:0]};
    end else if (pos_r == POS_W'(rhfd_pkg::SEQ_LO_POS)) begin
      seq_nxt = {seq_r[15:8], in_byte};
    end else if (pos_r >= POS_W'(rhfd_pkg::TS_FIRST_POS) &&
                 pos_r <= POS_W'(rhfd_pkg::TS_LAST_POS)) begin
      ts_nxt = {ts_r[23:0], in_byte};
    end

    gap = (seq_nxt != 16'd0) && (seq_nxt != prev_r + 16'd1);

    case (in_byte[7:5])
      rhfd_pkg::FU_START_FLAG: fu_kind = rhfd_pkg::KIND_FU_START;
      rhfd_pkg::FU_END_FLAG:   fu_kind = rhfd_pkg::KIND_FU_END;
      default:                 fu_kind = rhfd_pkg::KIND_FU_MIDDLE;
    endcase

    cmd       = '0;
    cmd.data  = in_byte;
    cmd.last  = in_last;
    cmd.seq   = seq_nxt;
    cmd.ts    = ts_nxt;
    cmd.gap   = gap;
    cmd.kind  = mode_r;
    cmd.ntype = fui_r[4:0];
    cmd.op    = rhfd_pkg::OP_DATA;

    if (pos_r < POS_W'(rhfd_pkg::HDR_LEN)) begin
      err = in_last;
    end else if (pos_r == POS_W'(rhfd_pkg::HDR_LEN)) begin
      fui_nxt  = in_byte;
      mode_nxt = rhfd_pkg::KIND_SINGLE;
      if (in_byte[4:0] == rhfd_pkg::FU_A_TYPE) begin
        err = in_last;
      end else begin
        has_cmd   = 1'b1;
        cmd.op    = rhfd_pkg::OP_START;
        cmd.kind  = rhfd_pkg::KIND_SINGLE;
        cmd.ntype = in_byte[4:0];
      end
    end else if (pos_r == POS_W'(rhfd_pkg::HDR_LEN + 1) &&
                 fui_r[4:0] == rhfd_pkg::FU_A_TYPE) begin
      // FU header: rebuild the NAL header, drop the byte itself
      fui_nxt   = {fui_r[7:5], in_byte[4:0]};
      mode_nxt  = fu_kind;
      cmd.kind  = fu_kind;
      cmd.ntype = in_byte[4:0];
      cmd.data  = fui_nxt;
      if (fu_kind == rhfd_pkg::KIND_FU_START) begin
        has_cmd = 1'b1;
        cmd.op  = rhfd_pkg::OP_START;
      end else if (in_last) begin
        has_cmd = 1'b1;
        cmd.op  = rhfd_pkg::OP_NO_DATA;
      end
    end else begin
      has_cmd = 1'b1;
    end

    if (in_last && err) begin
      cmd      = '0;
      cmd.op   = rhfd_pkg::OP_TOO_SHORT;
      cmd.last = 1'b1;
      has_cmd  = 1'b1;
    end

    if (in_last) begin
      pos_nxt = '0;
      if (!err) begin
        prev_nxt = seq_nxt;
      end
    end else if (pos_r < POS_MAX) begin
      pos_nxt = pos_r + 1'b1;
    end

    cmd_push = take && has_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      seq_r  <= '0;
      prev_r <= '0;
      ts_r   <= '0;
      fui_r  <= '0;
      mode_r <= rhfd_pkg::KIND_SINGLE;
    end else if (take) begin
      pos_r  <= pos_nxt;
      seq_r  <= seq_nxt;
      prev_r <= prev_nxt;
      ts_r   <= ts_nxt;
      fui_r  <= fui_nxt;
      mode_r <= mode_nxt;
    end
  end

  a_pos_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_MAX)
    else $error("packet position ran past its limit");

endmodule

FILE: design/rhfd_cmd_fifo.sv
// Short command queue between the classifier and the output sequencer.
module rhfd_cmd_fifo #(
  parameter int DEPTH = rhfd_pkg::CMD_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  rhfd_pkg::cmd_t wdata,
  output logic           full,
  input  logic           pop,
  output rhfd_pkg::cmd_t rdata,
  output logic           empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  rhfd_pkg::cmd_t   mem_r [DEPTH];
  logic [PTR_W-1:0] wptr_r, wptr_nxt;
  logic [PTR_W-1:0] rptr_r, rptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == CNT_W'(DEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (push) begin
      wptr_nxt = (wptr_r == PTR_W'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (pop) begin
      rptr_nxt = (rptr_r == PTR_W'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("command queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> cnt_r != '0)
    else $error("command queue read while empty");

endmodule

FILE: design/rhfd_back.sv
// Output sequencer: expands commands into Annex-B words, one word per cycle while pop is high.
module rhfd_back (
  input  logic           clk,
  input  logic           rst_n,
  input  rhfd_pkg::cmd_t head,
  input  logic           q_empty,
  output logic           q_pop,
  output logic           empty,
  input  logic           pop,
  output logic [7:0]     out_byte,
  output logic           out_last,
  output logic [1:0]     out_status,
  output logic [15:0]    out_seq_number,
  output logic [31:0]    out_time_stamp,
  output logic [1:0]     out_packet_kind,
  output logic [4:0]     out_nal_unit_type,
  output logic           out_seq_gap
);

  localparam int BEAT_W = rhfd_pkg::BEAT_W;

  rhfd_pkg::cmd_t    cur_r, cur_nxt;
  logic              valid_r, valid_nxt;
  logic [BEAT_W-1:0] beat_r, beat_nxt;
  logic              last_beat;
  logic              advance;

  assign last_beat = (cur_r.op != rhfd_pkg::OP_START) ||
                     (beat_r == BEAT_W'(rhfd_pkg::START_BEATS - 1));
  assign advance   = !valid_r || (pop && last_beat);
  assign q_pop     = advance && !q_empty;
  assign empty     = !valid_r;

  always_comb begin
    cur_nxt   = cur_r;
    valid_nxt = valid_r;
    beat_nxt  = beat_r;
    if (advance) begin
      valid_nxt = !q_empty;
      cur_nxt   = head;
      beat_nxt  = '0;
    end else if (pop) begin
      beat_nxt = beat_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      beat_r  <= '0;
    end else begin
      valid_r <= valid_nxt;
      beat_r  <= beat_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

  always_comb begin
    out_byte   = 8'h00;
    out_status = rhfd_pkg::ST_DATA;
    case (cur_r.op)
      rhfd_pkg::OP_DATA: begin
        out_byte = cur_r.data;
      end
      rhfd_pkg::OP_START: begin
        if (beat_r == BEAT_W'(rhfd_pkg::CODE_ONE_BEAT)) begin
          out_byte = rhfd_pkg::START_CODE_END;
        end else if (beat_r > BEAT_W'(rhfd_pkg::CODE_ONE_BEAT)) begin
          out_byte = cur_r.data;
        end
      end
      rhfd_pkg::OP_NO_DATA: begin
        out_status = rhfd_pkg::ST_NO_DATA;
      end
      rhfd_pkg::OP_TOO_SHORT: begin
        out_status = rhfd_pkg::ST_TOO_SHORT;
      end
      default: begin
        out_status = rhfd_pkg::ST_DATA;
      end
    endcase
  end

  assign out_last          = cur_r.last && last_beat;
  assign out_seq_number    = cur_r.seq;
  assign out_time_stamp    = cur_r.ts;
  assign out_packet_kind   = cur_r.kind;
  assign out_nal_unit_type = cur_r.ntype;
  assign out_seq_gap       = cur_r.gap;

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && !pop |=> valid_r && $stable(cur_r) && $stable(beat_r))
    else $error("output word changed while stalled");

  a_beat_only_in_burst: assert property (@(posedge clk) disable iff (!rst_n)
    beat_r != '0 |-> valid_r && cur_r.op == rhfd_pkg::OP_START)
    else $error("burst counter active outside a start-code burst");

endmodule

FILE: design/rtp_h264_fu_a_depacketizer_top.sv
// Top level of the RTP H.264 FU-A / single-NAL depacketizer to Annex-B.
//
// Feed an RTP packet one byte per push, with in_last on its final byte;
// results come out as a queue of words (pop/empty), one Annex-B byte per word
// along with the packet's sequence number, timestamp, packet kind, rebuilt
// NAL type and a sequence-gap flag. Header bytes, the FU indicator and the
// FU header of a middle or end fragment produce no words; a single-NAL packet
// gives a five-word burst (00 00 00 01 and the NAL header) on its NAL header
// byte, an FU-A start fragment the same burst on its FU header, and every
// later byte one word. A packet too short to carry a payload gives a single
// status-2 word; an FU-A middle or end fragment with no data gives a single
// status-1 word. out_last marks the last word of each packet. Rate: a byte is
// taken every cycle while full is low; the output sequencer delivers one word
// per cycle while pop is high, so the only slowdown is the four extra words
// of a start burst, absorbed by a CMD_DEPTH-entry command queue between the
// classifier and the sequencer (full rises only when that queue fills). With
// the queue and sequencer idle, the first word of an accepted byte is written
// into the command queue and then loaded into the sequencer's output register,
// which drives the result ports. Packets longer than MAX_PACKET bytes pass
// through whole; the internal position counter just saturates.
module rtp_h264_fu_a_depacketizer_top #(
  parameter int MAX_PACKET = rhfd_pkg::MAX_PACKET_DEF,
  parameter int CMD_DEPTH  = rhfd_pkg::CMD_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input word channel
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_byte,
  input  logic        in_last,
  // result word channel
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte,
  output logic        out_last,
  output logic [1:0]  out_status,
  output logic [15:0] out_seq_number,
  output logic [31:0] out_time_stamp,
  output logic [1:0]  out_packet_kind,
  output logic [4:0]  out_nal_unit_type,
  output logic        out_seq_gap
);

  rhfd_pkg::cmd_t front_cmd;
  rhfd_pkg::cmd_t q_head;
  logic           cmd_push;
  logic           q_full;
  logic           q_empty;
  logic           q_pop;
  logic           take;

  assign full = q_full;
  assign take = push && !q_full;

  rhfd_front #(
    .MAX_PACKET(MAX_PACKET)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .take     (take),
    .in_byte  (in_byte),
    .in_last  (in_last),
    .cmd      (front_cmd),
    .cmd_push (cmd_push)
  );

  rhfd_cmd_fifo #(
    .DEPTH(CMD_DEPTH)
  ) u_cmd_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .wdata (front_cmd),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_head),
    .empty (q_empty)
  );

  rhfd_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head              (q_head),
    .q_empty           (q_empty),
    .q_pop             (q_pop),
    .empty             (empty),
    .pop               (pop),
    .out_byte          (out_byte),
    .out_last          (out_last),
    .out_status        (out_status),
    .out_seq_number    (out_seq_number),
    .out_time_stamp    (out_time_stamp),
    .out_packet_kind   (out_packet_kind),
    .out_nal_unit_type (out_nal_unit_type),
    .out_seq_gap       (out_seq_gap)
  );

endmodule

FILE: bench/rtp_h264_fu_a_depacketizer_top_test.sv
// Self-checking bench for the RTP H.264 FU-A depacketizer: directed and random packets.
module rtp_h264_fu_a_depacketizer_top_test;

  // Timeout: far above the slowest legal run (every byte a five-word burst,
  // every word held off by the longest receiver stall).
  localparam int LIMIT_CYCLES = 3_000_000;
  // Settle time after the last expected word.
  localparam int DRAIN_CYCLES = 20;
  localparam int REPORT_MAX   = 10;
  // Small packet limit, so a long packet stays short.
  localparam int TB_MAX_PACKET = 64;

  // One output word as the block presents it, fields in port order.
  typedef struct packed {
    logic [7:0]         data;
    logic               last;
    rhfd_pkg::status_t  status;
    logic [15:0]        seq;
    logic [31:0]        ts;
    rhfd_pkg::kind_t    kind;
    logic [4:0]         ntype;
    logic               gap;
  } annexb_word_t;

  logic        clk     = 1'b0;
  logic        rst_n   = 1'b0;
  logic        push    = 1'b0;
  logic [7:0]  in_byte = 8'h00;
  logic        in_last = 1'b0;
  logic        pop     = 1'b0;
  logic        full;
  logic        empty;
  logic [7:0]  out_byte;
  logic        out_last;
  logic [1:0]  out_status;
  logic [15:0] out_seq_number;
  logic [31:0] out_time_stamp;
  logic [1:0]  out_packet_kind;
  logic [4:0]  out_nal_unit_type;
  logic        out_seq_gap;

  // Depacketizer state as the bench tracks it (all zero out of reset).
  int              pkt_pos   = 0;
  logic [15:0]     pkt_seq   = 16'h0000;
  logic [15:0]     last_seq  = 16'h0000;
  logic [31:0]     pkt_ts    = 32'h0000_0000;
  logic [7:0]      nal_hdr   = 8'h00;
  rhfd_pkg::kind_t frag_kind = rhfd_pkg::KIND_SINGLE;

  annexb_word_t annexb_q[$];   // words still owed by the block, oldest first
  logic [7:0]   pkt_buf[$];    // packet being assembled for sending
  logic [15:0]  next_seq   = 16'h0000;
  logic         calm       = 1'b0;   // set for the tail: no idling on either side
  int           stall_left = 0;
  int           mismatches = 0;
  int           cycles     = 0;

  rtp_h264_fu_a_depacketizer_top #(
    .MAX_PACKET(TB_MAX_PACKET)
  ) u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .push              (push),
    .full              (full),
    .in_byte           (in_byte),
    .in_last           (in_last),
    .empty             (empty),
    .pop               (pop),
    .out_byte          (out_byte),
    .out_last          (out_last),
    .out_status        (out_status),
    .out_seq_number    (out_seq_number),
    .out_time_stamp    (out_time_stamp),
    .out_packet_kind   (out_packet_kind),
    .out_nal_unit_type (out_nal_unit_type),
    .out_seq_gap       (out_seq_gap)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("rtp_h264_fu_a_depacketizer_top_test: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Expected-word generation
  // ---------------------------------------------------------------------------

  function automatic void push_word(logic [7:0] d, rhfd_pkg::status_t st,
                                    rhfd_pkg::kind_t k, logic [4:0] t, logic g);
    annexb_word_t w;
    w.data   = d;
    w.last   = 1'b0;
    w.status = st;
    w.seq    = pkt_seq;
    w.ts     = pkt_ts;
    w.kind   = k;
    w.ntype  = t;
    w.gap    = g;
    annexb_q.push_back(w);
  endfunction

  // 00 00 00 01 followed by the NAL header byte
  function automatic void push_start_code(logic [7:0] hdr, rhfd_pkg::kind_t k, logic g);
    for (int i = 0; i < rhfd_pkg::START_BEATS; i++)
      push_word((i == rhfd_pkg::START_BEATS - 1) ? hdr :
                (i == rhfd_pkg::CODE_ONE_BEAT) ? rhfd_pkg::START_CODE_END : 8'h00,
                rhfd_pkg::ST_DATA, k, hdr[4:0], g);
  endfunction

  // Advance the tracked state by one accepted byte and queue the words it owes.
  function automatic void depacketize(logic [7:0] b, logic l);
    annexb_word_t w;
    int           pos;
    int           base;
    logic         g;
    logic         too_short;
    logic [2:0]   flag;
    pos       = pkt_pos;
    base      = annexb_q.size();
    too_short = 1'b0;

    if (pos == rhfd_pkg::SEQ_HI_POS)
      pkt_seq[15:8] = b;
    else if (pos == rhfd_pkg::SEQ_LO_POS)
      pkt_seq[7:0] = b;
    else if (pos >= rhfd_pkg::TS_FIRST_POS && pos <= rhfd_pkg::TS_LAST_POS)
      pkt_ts = {pkt_ts[23:0], b};

    // Sequence zero never counts as a gap.
    g = (pkt_seq != 16'h0000) && (pkt_seq != 16'(last_seq + 16'd1));

    if (pos < rhfd_pkg::HDR_LEN) begin
      too_short = l;
    end else if (pos == rhfd_pkg::HDR_LEN) begin
      nal_hdr   = b;
      frag_kind = rhfd_pkg::KIND_SINGLE;
      if (b[4:0] == rhfd_pkg::FU_A_TYPE)
        too_short = l;     // FU-A packet ending on its indicator
      else
        push_start_code(b, rhfd_pkg::KIND_SINGLE, g);
    end else if (pos == rhfd_pkg::HDR_LEN + 1 && nal_hdr[4:0] == rhfd_pkg::FU_A_TYPE) begin
      // FU header: S/E/R bits decide the kind; anything but a clean S or a clean E
      // (both set, or R set) is a middle fragment.
      flag      = b[7:5];
      frag_kind = (flag == rhfd_pkg::FU_START_FLAG) ? rhfd_pkg::KIND_FU_START :
                  (flag == rhfd_pkg::FU_END_FLAG)   ? rhfd_pkg::KIND_FU_END   :
                                                      rhfd_pkg::KIND_FU_MIDDLE;
      nal_hdr   = {nal_hdr[7:5], b[4:0]};
      if (frag_kind == rhfd_pkg::KIND_FU_START)
        push_start_code(nal_hdr, frag_kind, g);
    end else begin
      push_word(b, rhfd_pkg::ST_DATA, frag_kind, nal_hdr[4:0], g);
    end

    if (l) begin
      if (too_short) begin
        // Lone error word, all other fields zero; previous sequence kept.
        w        = '0;
        w.last   = 1'b1;
        w.status = rhfd_pkg::ST_TOO_SHORT;
        annexb_q.push_back(w);
      end else begin
        if (annexb_q.size() == base)
          push_word(8'h00, rhfd_pkg::ST_NO_DATA, frag_kind, nal_hdr[4:0], g);
        annexb_q[annexb_q.size() - 1].last = 1'b1;
        last_seq = pkt_seq;
      end
      pkt_pos = 0;
    end else if (pkt_pos < TB_MAX_PACKET - 1) begin
      pkt_pos = pkt_pos + 1;   // saturates on long packets
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  function automatic string word_text(annexb_word_t w);
    return $sformatf("byte=%02h last=%0d status=%0d seq=%04h ts=%08h %s",
                     w.data, w.last, w.status, w.seq, w.ts,
                     $sformatf("kind=%0d type=%02h gap=%0d", w.kind, w.ntype, w.gap));
  endfunction

  function automatic void flag_error(string what, annexb_word_t want, annexb_word_t got);
    mismatches++;
    if (mismatches <= REPORT_MAX)
      $display("cycle %0d %s: expected %s / actual %s", cycles, what, word_text(want),
               word_text(got));
  endfunction

  // Sampled at the rising edge, before the block's own updates land.
  always @(posedge clk) begin : check_words
    annexb_word_t got;
    annexb_word_t want;
    if (rst_n && pop && !empty) begin
      got = {out_byte, out_last, out_status, out_seq_number, out_time_stamp,
             out_packet_kind, out_nal_unit_type, out_seq_gap};
      if (annexb_q.size() == 0) begin
        flag_error("word with none expected", '0, got);
      end else begin
        want = annexb_q.pop_front();
        if (got.data !== want.data || got.last !== want.last || got.status !== want.status ||
            got.seq !== want.seq || got.ts !== want.ts || got.kind !== want.kind ||
            got.ntype !== want.ntype || got.gap !== want.gap)
          flag_error("word mismatch", want, got);
      end
    end
  end

  // Receiver: random bursts of stalled cycles, none once calm.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      pop        <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      pop        <= 1'b0;
      stall_left <= $urandom_range(0, 11);
    end else begin
      pop <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Called at a falling edge, returns at a falling edge. push stays high between
  // back-to-back words so it is never dropped and raised in one step.
  task automatic send_byte(logic [7:0] b, logic l);
    if (!calm && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    push    <= 1'b1;
    in_byte <= b;
    in_last <= l;
    do @(posedge clk); while (full);
    depacketize(b, l);
    @(negedge clk);
  endtask

  task automatic send_packet();
    for (int i = 0; i < pkt_buf.size(); i++)
      send_byte(pkt_buf[i], i == pkt_buf.size() - 1);
  endtask

  // 12-byte RTP header; flags, PT and SSRC are don't-care for the block
  function automatic void rtp_header(logic [15:0] seq);
    logic [31:0] ts;
    ts = $urandom;
    pkt_buf.delete();
    pkt_buf.push_back(8'($urandom));
    pkt_buf.push_back(8'($urandom));
    pkt_buf.push_back(seq[15:8]);
    pkt_buf.push_back(seq[7:0]);
    for (int i = 3; i >= 0; i--)
      pkt_buf.push_back(ts[8*i +: 8]);
    repeat (4) pkt_buf.push_back(8'($urandom));
  endfunction

  function automatic void add_payload(int n);
    repeat (n) pkt_buf.push_back(8'($urandom));
  endfunction

  function automatic void build_single(logic [15:0] seq, logic [7:0] hdr, int n);
    rtp_header(seq);
    pkt_buf.push_back(hdr);
    add_payload(n);
  endfunction

  // se_r is the FU header's S, E and R bits
  function automatic void build_fu(logic [15:0] seq, logic [2:0] se_r, int n);
    rtp_header(seq);
    pkt_buf.push_back({3'($urandom), rhfd_pkg::FU_A_TYPE});
    pkt_buf.push_back({se_r, 5'($urandom)});
    add_payload(n);
  endfunction

  function automatic void truncate_to(int n);
    while (pkt_buf.size() > n)
      void'(pkt_buf.pop_back());
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Single NAL packets: type extremes, header-only payload, payload byte extremes
  // and a sequence gap up to 0xffff.
  task automatic test_single_nal();
    build_single(16'h0000, 8'h00, 0);
    send_packet();
    build_single(16'h0001, 8'hff, 0);
    pkt_buf.push_back(8'h00);
    pkt_buf.push_back(8'hff);
    send_packet();
    build_single(16'hffff, 8'h65, 1);   // gap
    send_packet();
  endtask

  // FU-A fragments of every kind, with and without data.
  task automatic test_fu_a();
    build_fu(16'h0000, 3'b100, 1);   // start, wrapped sequence: zero never flags
    send_packet();
    build_fu(16'h0001, 3'b000, 1);   // middle
    send_packet();
    build_fu(16'h0002, 3'b010, 1);   // end
    send_packet();
    build_fu(16'h0003, 3'b110, 0);   // S and E together: middle, no data
    send_packet();
    build_fu(16'h0004, 3'b101, 0);   // reserved bit spoils the start flag
    send_packet();
    build_fu(16'h0005, 3'b100, 0);   // start with nothing after the FU header
    send_packet();
    build_fu(16'h0005, 3'b011, 0);   // repeated sequence: gap
    send_packet();
  endtask

  // Packets too short for a payload; the following packet checks that the
  // previous sequence was left alone.
  task automatic test_short_packets();
    rtp_header(16'h5555);
    truncate_to(1);
    send_packet();
    rtp_header(16'h5555);
    truncate_to(4);
    send_packet();
    rtp_header(16'h7777);
    truncate_to(rhfd_pkg::HDR_LEN);
    send_packet();
    build_fu(16'h7778, 3'b100, 0);   // ends on the FU indicator
    truncate_to(rhfd_pkg::HDR_LEN + 1);
    send_packet();
    build_single(16'h0006, 8'h01, 0);
    send_packet();
    next_seq = 16'h0007;
  endtask

  // Packet longer than the position counter's range passes through whole.
  task automatic test_long_packet();
    build_single(next_seq, 8'h25, TB_MAX_PACKET - rhfd_pkg::HDR_LEN + 3);
    send_packet();
    next_seq = next_seq + 16'd1;
  endtask

  // Mostly well-formed packets with random content; some noise and truncation.
  task automatic test_random_packets(int count);
    int          pick;
    logic [15:0] seq;
    logic [4:0]  t;
    logic [2:0]  se_r;
    repeat (count) begin
      pick = $urandom_range(0, 9);
      seq  = ($urandom_range(0, 7) == 0) ? 16'($urandom) : next_seq;
      if (pick == 0) begin
        pkt_buf.delete();
        add_payload($urandom_range(1, 16));
      end else if (pick <= 3) begin
        t = 5'($urandom_range(0, 30));
        if (t >= rhfd_pkg::FU_A_TYPE)
          t = t + 5'd1;   // keep clear of the FU-A type
        build_single(seq, {3'($urandom), t}, $urandom_range(0, 6));
      end else begin
        case ($urandom_range(0, 3))
          0: se_r = 3'b100;
          1: se_r = 3'b000;
          2: se_r = 3'b010;
          default: se_r = 3'($urandom);
        endcase
        build_fu(seq, se_r, $urandom_range(0, 6));
      end
      if (pick != 0 && $urandom_range(0, 9) == 0)
        truncate_to($urandom_range(1, rhfd_pkg::HDR_LEN + 1));
      send_packet();
      next_seq = seq + 16'd1;
    end
  endtask

  // Tail of the run: both sides at full rate.
  task automatic test_back_to_back();
    calm = 1'b1;
    test_random_packets(2);
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    test_single_nal();
    test_fu_a();
    test_short_packets();
    test_long_packet();
    test_random_packets(3);
    test_back_to_back();

    push <= 1'b0;
    while (annexb_q.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatches == 0)
      $display("rtp_h264_fu_a_depacketizer_top_test: clean");
    else
      $display("rtp_h264_fu_a_depacketizer_top_test: errors");
    $finish;
  end

endmodule
